FILE: hw/rtl/battery_status_estimator_assert.svh
// ----------------------------------------------------------------------------
// battery status estimator assertion macros
// clocked on clk, disabled while rst is high
// ----------------------------------------------------------------------------
`ifndef BATTERY_STATUS_ESTIMATOR_ASSERT_SVH
`define BATTERY_STATUS_ESTIMATOR_ASSERT_SVH

// same-cycle implication
`define BSE_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: property failed");

// next-cycle implication
`define BSE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: property failed");

`endif

FILE: hw/rtl/bse_pkg.sv
// ----------------------------------------------------------------------------
// bse_pkg
// types, codes and constants shared by the battery status estimator
// ----------------------------------------------------------------------------
package bse_pkg;

  typedef logic [7:0] volt_t;
  typedef logic [7:0] flags_t;
  typedef logic [1:0] code_t;
  typedef logic [9:0] pct_t;
  typedef logic       reg_idx_t;

  // charger flag decode
  localparam flags_t STATE_MASK    = 8'd6;
  localparam flags_t CHARGED_CODE  = 8'd2;
  localparam flags_t CHARGING_CODE = 8'd6;
  localparam flags_t ADAPTER_BIT   = 8'd16;

  // charge state
  localparam code_t ST_DISCHARGING = 2'd0;
  localparam code_t ST_CHARGING    = 2'd1;
  localparam code_t ST_CHARGED     = 2'd2;

  // charge source
  localparam code_t SRC_NONE    = 2'd0;
  localparam code_t SRC_ADAPTER = 2'd1;
  localparam code_t SRC_DOCK    = 2'd2;

  // battery level
  localparam code_t LVL_DANGEROUS = 2'd0;
  localparam code_t LVL_LOW       = 2'd1;
  localparam code_t LVL_HEALTHY   = 2'd2;
  localparam code_t LVL_MAXIMUM   = 2'd3;

  // register indexes
  localparam reg_idx_t REG_LOW    = 1'b0;
  localparam reg_idx_t REG_DANGER = 1'b1;

  localparam volt_t LOW_RESET    = 8'd140;
  localparam volt_t DANGER_RESET = 8'd132;
  localparam volt_t FULL_RESET   = 8'd165;

  localparam pct_t PCT_MAX  = 10'd1000;
  localparam pct_t PCT_ZERO = 10'd0;

  localparam int QUOT_BITS = 10;
  localparam int CNT_W     = $clog2(QUOT_BITS);

  typedef struct packed {
    logic capture;
    logic load;
    logic check;
    logic step;
    logic result_load;
  } dp_cmd_t;

  typedef struct packed {
    logic skip;
  } dp_status_t;

endpackage

FILE: hw/rtl/bse_report_if.sv
// ----------------------------------------------------------------------------
// bse_report_if
// sensor report channel: voltage and charger flags
// ----------------------------------------------------------------------------
interface bse_report_if;
  logic            valid;
  logic            ready;
  bse_pkg::volt_t  voltage_tenths;
  bse_pkg::flags_t charger_flags;

  modport source (output valid, voltage_tenths, charger_flags, input ready);
  modport sink (input valid, voltage_tenths, charger_flags, output ready);
endinterface

FILE: hw/rtl/bse_result_if.sv
// ----------------------------------------------------------------------------
// bse_result_if
// status result channel: state, source, level and charge estimate
// ----------------------------------------------------------------------------
interface bse_result_if;
  logic           valid;
  logic           ready;
  bse_pkg::code_t charge_state;
  bse_pkg::code_t charge_source;
  bse_pkg::code_t battery_level;
  bse_pkg::pct_t  percent_tenths;

  modport source (output valid, charge_state, charge_source, battery_level,
                  percent_tenths, input ready);
  modport sink (input valid, charge_state, charge_source, battery_level,
                percent_tenths, output ready);
endinterface

FILE: hw/rtl/bse_cfg_if.sv
// ----------------------------------------------------------------------------
// bse_cfg_if
// register write channel: index and data
// ----------------------------------------------------------------------------
interface bse_cfg_if;
  logic              valid;
  logic              ready;
  bse_pkg::reg_idx_t index;
  bse_pkg::volt_t    data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: hw/rtl/bse_datapath.sv
// ----------------------------------------------------------------------------
// bse_datapath
// flag decode, level compare, span set-up and restoring divider
// ----------------------------------------------------------------------------
module bse_datapath (
  input  logic                clk,
  input  logic                rst,
  input  bse_pkg::dp_cmd_t    cmd,
  output bse_pkg::dp_status_t status,
  input  bse_pkg::volt_t      voltage_tenths,
  input  bse_pkg::flags_t     charger_flags,
  input  bse_pkg::volt_t      low_threshold,
  input  bse_pkg::volt_t      danger_threshold,
  output bse_pkg::code_t      charge_state,
  output bse_pkg::code_t      charge_source,
  output bse_pkg::code_t      battery_level,
  output bse_pkg::pct_t       percent_tenths
);
  import bse_pkg::*;

  volt_t v_r;
  flags_t flags_r;
  volt_t full_voltage;
  code_t state_r;
  code_t source_r;
  code_t level_r;
  logic signed [19:0] num_r;
  logic signed [8:0]  den_r;
  logic [17:0] lim_r;
  logic diff_pos_r;
  logic [17:0] rem_r;
  logic [17:0] dsh_r;
  logic [QUOT_BITS-1:0] quot_r;
  pct_t pct_r;
  logic skip_r;

  flags_t s;
  code_t st;
  code_t src;
  code_t lvl;
  volt_t f_eff;
  logic signed [8:0] den;
  logic signed [8:0] diff;
  logic signed [19:0] num;
  logic [17:0] lim;
  logic degen;
  logic num_nonpos;
  logic num_over;
  pct_t pct_early;

  function automatic flags_t charger_flags_r_mask(input flags_t f);
    return f & STATE_MASK;
  endfunction

  // decode and span set-up
  always_comb begin
    s = charger_flags_r_mask(flags_r);
    if (s == CHARGING_CODE) begin
      st = ST_CHARGING;
    end else if (s == CHARGED_CODE) begin
      st = ST_CHARGED;
    end else begin
      st = ST_DISCHARGING;
    end
    if (st == ST_DISCHARGING) begin
      src = SRC_NONE;
    end else if ((flags_r & ADAPTER_BIT) != 8'd0) begin
      src = SRC_ADAPTER;
    end else begin
      src = SRC_DOCK;
    end
    if (st == ST_CHARGED) begin
      lvl = LVL_MAXIMUM;
    end else if (v_r > low_threshold) begin
      lvl = LVL_HEALTHY;
    end else if (v_r > danger_threshold) begin
      lvl = LVL_LOW;
    end else begin
      lvl = LVL_DANGEROUS;
    end
    f_eff = (st == ST_CHARGED) ? v_r : full_voltage;
    den   = $signed({1'b0, f_eff}) - $signed({1'b0, danger_threshold});
    diff  = $signed({1'b0, v_r}) - $signed({1'b0, danger_threshold});
    num   = 20'(den) * 20'sd50 + 20'(diff) * 20'sd950;
    lim   = 18'(den[7:0]) * 18'd1001;
  end

  // early-out checks
  always_comb begin
    degen      = (den_r <= 9'sd0);
    num_nonpos = num_r[19] || (num_r == 20'sd0);
    num_over   = (num_r[17:0] >= lim_r);
    if (degen) begin
      pct_early = diff_pos_r ? PCT_MAX : PCT_ZERO;
    end else if (num_nonpos) begin
      pct_early = PCT_ZERO;
    end else begin
      pct_early = PCT_MAX;
    end
    status.skip = degen || num_nonpos || num_over;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      full_voltage <= FULL_RESET;
    end else if (cmd.load && st == ST_CHARGED) begin
      full_voltage <= v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      v_r     <= voltage_tenths;
      flags_r <= charger_flags;
    end
    if (cmd.load) begin
      state_r    <= st;
      source_r   <= src;
      level_r    <= lvl;
      num_r      <= num;
      den_r      <= den;
      lim_r      <= lim;
      diff_pos_r <= (diff > 9'sd0);
    end
    if (cmd.check) begin
      skip_r <= status.skip;
      pct_r  <= pct_early;
      rem_r  <= num_r[17:0];
      dsh_r  <= 18'(den_r[7:0]) << (QUOT_BITS - 1);
      quot_r <= '0;
    end
    if (cmd.step) begin
      if (rem_r >= dsh_r) begin
        rem_r  <= rem_r - dsh_r;
        quot_r <= {quot_r[QUOT_BITS-2:0], 1'b1};
      end else begin
        quot_r <= {quot_r[QUOT_BITS-2:0], 1'b0};
      end
      dsh_r <= dsh_r >> 1;
    end
    if (cmd.result_load) begin
      charge_state   <= state_r;
      charge_source  <= source_r;
      battery_level  <= level_r;
      percent_tenths <= skip_r ? pct_r : pct_t'(quot_r);
    end
  end

endmodule

FILE: hw/rtl/bse_controller.sv
// ----------------------------------------------------------------------------
// bse_controller
// sequencer for one report at a time and the result register handshake
// ----------------------------------------------------------------------------
module bse_controller (
  input  logic                clk,
  input  logic                rst,
  input  logic                report_valid,
  output logic                report_ready,
  output logic                result_valid,
  input  logic                result_ready,
  output bse_pkg::dp_cmd_t    cmd,
  input  bse_pkg::dp_status_t status
);
  import bse_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_LOAD   = 5'b00010,
    S_CHECK  = 5'b00100,
    S_DIV    = 5'b01000,
    S_FINISH = 5'b10000
  } ctrl_state_t;

  ctrl_state_t state;
  ctrl_state_t state_next;
  logic [CNT_W-1:0] cnt;
  logic out_free;

  assign report_ready = (state == S_IDLE);
  assign out_free     = !result_valid || result_ready;

  always_comb begin
    state_next      = state;
    cmd             = '0;
    unique case (state)
      S_IDLE: begin
        cmd.capture = report_valid;
        if (report_valid) state_next = S_LOAD;
      end
      S_LOAD: begin
        cmd.load   = 1'b1;
        state_next = S_CHECK;
      end
      S_CHECK: begin
        cmd.check  = 1'b1;
        state_next = status.skip ? S_FINISH : S_DIV;
      end
      S_DIV: begin
        cmd.step = 1'b1;
        if (cnt == CNT_W'(QUOT_BITS - 1)) state_next = S_FINISH;
      end
      S_FINISH: begin
        cmd.result_load = out_free;
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      cnt          <= '0;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_DIV) begin
        cnt <= cnt + 1'b1;
      end else begin
        cnt <= '0;
      end
      if (cmd.result_load) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

endmodule

FILE: hw/rtl/battery_status_estimator.sv
// each report is captured, loaded and checked, then runs the ten-step divider unless
//   the estimate is settled early (flat span, non-positive or saturated value)
// reports are taken one at a time, the next only once the last result is loaded
// the result register lets the next report in while a result beat waits
// reset: synchronous, thresholds 140 and 132, full-charge voltage 165
// ----------------------------------------------------------------------------
// battery_status_estimator
// charger flag decode, battery level and charge percentage estimate
// ----------------------------------------------------------------------------
`include "battery_status_estimator_assert.svh"

module battery_status_estimator (
  input logic   clk,
  input logic   rst,
  bse_report_if.sink   report,
  bse_result_if.source result,
  bse_cfg_if.sink      cfg
);
  import bse_pkg::*;

  volt_t low_threshold;
  volt_t danger_threshold;
  dp_cmd_t cmd;
  dp_status_t status;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      low_threshold    <= LOW_RESET;
      danger_threshold <= DANGER_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_LOW:    low_threshold    <= cfg.data;
        REG_DANGER: danger_threshold <= cfg.data;
        default: ;
      endcase
    end
  end

  bse_controller u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .report_valid (report.valid),
    .report_ready (report.ready),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .cmd          (cmd),
    .status       (status)
  );

  bse_datapath u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .status           (status),
    .voltage_tenths   (report.voltage_tenths),
    .charger_flags    (report.charger_flags),
    .low_threshold    (low_threshold),
    .danger_threshold (danger_threshold),
    .charge_state     (result.charge_state),
    .charge_source    (result.charge_source),
    .battery_level    (result.battery_level),
    .percent_tenths   (result.percent_tenths)
  );

  `BSE_ASSERT_NOW(a_pct_range, result.valid, result.percent_tenths <= PCT_MAX)
  `BSE_ASSERT_NOW(a_charged_max, result.valid && result.charge_state == ST_CHARGED,
                  result.battery_level == LVL_MAXIMUM)
  `BSE_ASSERT_NOW(a_disch_none, result.valid && result.charge_state == ST_DISCHARGING,
                  result.charge_source == SRC_NONE)
  `BSE_ASSERT_NEXT(a_one_at_a_time, report.valid && report.ready, !report.ready)

endmodule
